/* rtl/core/ypd_pkg.sv */
// Shared types and constants of the YIN pitch detector.
package ypd_pkg;

  // Field widths fixed by the interface
  localparam int SAMPLE_W   = 16;
  localparam int THRESH_W   = 16;
  localparam int RATE_W     = 18;
  localparam int WINREG_W   = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 18;
  localparam int ND_W       = 20;
  localparam int FREQ_W     = 19;
  localparam int CONF_W     = 17;
  localparam int SUM_W      = 56;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW    = 2'd2;

  // Reset values of the configuration registers
  localparam logic [THRESH_W-1:0] THRESHOLD_RST = 16'd9830;
  localparam logic [RATE_W-1:0]   RATE_RST      = 18'd48000;
  localparam logic [WINREG_W-1:0] WINDOW_RST    = 13'd2208;
  localparam logic [WINREG_W-1:0] MIN_WINDOW    = 13'd1024;

  // Arithmetic limits
  localparam logic [ND_W-1:0]   NORM_MAX = 20'hFFFFF;
  localparam logic [SUM_W-1:0]  SUM_MAX  = {SUM_W{1'b1}};
  localparam logic [FREQ_W-1:0] FREQ_LO  = 19'd15360;
  localparam logic [FREQ_W-1:0] FREQ_HI  = 19'd307200;

  // Input queue between the front and the analysis engine
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = 2;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       block_end;
  } in_beat_t;

  typedef struct packed {
    logic              pitch_found;
    logic [FREQ_W-1:0] frequency_q8;
    logic [CONF_W-1:0] confidence_q16;
    logic              voiced;
  } out_beat_t;

  typedef struct packed {
    logic [THRESH_W-1:0] threshold;
    logic [RATE_W-1:0]   rate;
  } cfg_t;

endpackage

/* rtl/core/ypd_queue.sv */
// Short input queue that decouples sample acceptance from the analysis engine.
module ypd_queue
  import ypd_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  in_beat_t push_data,
  output logic     full,
  input  logic     pop,
  output in_beat_t pop_data,
  output logic     not_empty
);

  in_beat_t              entries [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]   wr_ptr;
  logic [QUEUE_AW-1:0]   rd_ptr;
  logic [QUEUE_AW:0]     count;

  assign full      = (count == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign pop_data  = entries[rd_ptr];

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_data;
  end

endmodule

/* rtl/core/ypd_divider.sv */
// Restoring unsigned divider, one quotient bit per cycle.
module ypd_divider #(
  parameter int NW = 70,
  parameter int VW = 56
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [VW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quo,
  output logic [VW-1:0] rem
);

  localparam int CW = $clog2(NW + 1);

  logic [VW-1:0] den_r;
  logic [CW-1:0] cnt;
  logic          run;
  logic [VW:0]   trial;
  logic          ge;

  // Bring down the next dividend bit and try the subtraction
  always_comb begin
    trial = {rem, quo[NW-1]};
    ge    = (trial >= {1'b0, den_r});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= CW'(NW);
      end else if (run) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Partial remainder and quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= '0;
      quo   <= num;
      den_r <= den;
    end else if (run) begin
      rem <= ge ? VW'(trial - {1'b0, den_r}) : trial[VW-1:0];
      quo <= {quo[NW-2:0], ge};
    end
  end

endmodule

/* rtl/core/ypd_engine.sv */
// Back end: sample ring, YIN difference and normalisation loop, dip search, refinement and frequency division.
module ypd_engine
  import ypd_pkg::*;
#(
  parameter int MAX_WINDOW = 4096
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic [$clog2(MAX_WINDOW+1)-1:0]    win,
  input  logic                               win_clear,
  input  cfg_t                               cfg,
  input  logic                               q_valid,
  input  in_beat_t                           q_data,
  output logic                               q_pop,
  output logic                               out_valid,
  input  logic                               out_ready,
  output out_beat_t                          out_data
);

  localparam int AW  = $clog2(MAX_WINDOW);
  localparam int WW  = $clog2(MAX_WINDOW + 1);
  localparam int TW  = AW - 1;
  localparam int DW  = 31 + AW;
  localparam int PW  = DW + TW;
  localparam int NW  = PW + 16;
  localparam int LGW = ((TW + 16 > 36) ? TW + 16 : 36) + 2;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_ACC    = 4'd1;
  localparam logic [3:0] S_MUL    = 4'd2;
  localparam logic [3:0] S_DIVS   = 4'd3;
  localparam logic [3:0] S_DIVW   = 4'd4;
  localparam logic [3:0] S_REF    = 4'd5;
  localparam logic [3:0] S_REFW   = 4'd6;
  localparam logic [3:0] S_LAG    = 4'd7;
  localparam logic [3:0] S_FRQW   = 4'd8;
  localparam logic [3:0] S_FINISH = 4'd9;

  logic [3:0]                 state;
  logic signed [SAMPLE_W-1:0] ring [MAX_WINDOW];
  logic [AW-1:0]              wp;
  logic [WW-1:0]              fill;
  logic [TW-1:0]              t;
  logic [TW-1:0]              i;
  logic                       iss;
  logic                       rd_v;
  logic                       sq_v;
  logic signed [SAMPLE_W-1:0] rd_a;
  logic signed [SAMPLE_W-1:0] rd_b;
  logic [31:0]                sq;
  logic [DW-1:0]              acc;
  logic [SUM_W-1:0]           rs;
  logic [PW-1:0]              prod;
  logic                       walk;
  logic                       found;
  logic                       have_y2;
  logic [ND_W-1:0]            prev_nd;
  logic [ND_W-1:0]            y0;
  logic [ND_W-1:0]            y1;
  logic [ND_W-1:0]            y2;
  logic [TW-1:0]              tau;
  logic                       neg;
  logic signed [LGW-1:0]      lag;
  out_beat_t                  pend;

  // Combinational helpers
  logic [TW-1:0]              hm1;
  logic [AW:0]                wp_inc;
  logic [WW-1:0]              fill_next;
  logic [AW:0]                sum_a;
  logic [AW:0]                sum_b;
  logic [AW-1:0]              a_idx;
  logic [AW-1:0]              b_idx;
  logic signed [SAMPLE_W:0]   delta;
  logic signed [2*SAMPLE_W+1:0] sq_full;
  logic [SUM_W:0]             rs_sum;
  logic [ND_W-1:0]            nd;
  logic                       last;
  logic                       hit_first;
  logic                       go_down;
  logic                       s_end;
  logic signed [ND_W:0]       num_s;
  logic signed [ND_W:0]       num_abs;
  logic signed [24:0]         den_s;
  logic signed [24:0]         den_abs;
  logic signed [LGW-1:0]      q_signed;
  logic signed [LGW-1:0]      lag_next;
  logic                       lag_pos;
  logic                       in_range;
  logic                       div_start;
  logic [NW-1:0]              div_num;
  logic [SUM_W-1:0]           div_den;
  logic                       div_done;
  logic [NW-1:0]              div_q;
  logic [SUM_W-1:0]           div_r;

  // Shared divider for normalisation, refinement and frequency
  ypd_divider #(.NW(NW), .VW(SUM_W)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_q),
    .rem   (div_r)
  );

  // Ring addressing, oldest sample first
  always_comb begin
    hm1       = TW'(win[WW-1:1] - 1'b1);
    wp_inc    = {1'b0, wp} + 1'b1;
    fill_next = (fill < win) ? fill + 1'b1 : fill;
    sum_a     = {1'b0, wp} + (AW+1)'(i);
    sum_b     = {1'b0, wp} + (AW+1)'(i) + (AW+1)'(t);
    a_idx     = (sum_a >= win) ? AW'(sum_a - (AW+1)'(win)) : sum_a[AW-1:0];
    b_idx     = (sum_b >= win) ? AW'(sum_b - (AW+1)'(win)) : sum_b[AW-1:0];
    delta     = $signed({rd_a[SAMPLE_W-1], rd_a}) - $signed({rd_b[SAMPLE_W-1], rd_b});
    sq_full   = delta * delta;
    rs_sum    = {1'b0, rs} + (SUM_W+1)'(acc);
  end

  // Normalised value and the streaming dip search
  always_comb begin
    if (rs == '0) nd = '0;
    else if (div_q > NW'(NORM_MAX)) nd = NORM_MAX;
    else nd = div_q[ND_W-1:0];
    last      = (t == hm1);
    hit_first = !walk && (t >= TW'(2)) && (nd < cfg.threshold);
    go_down   = walk && (nd < y1);
    s_end     = last || hit_first && last || (walk && !go_down);
  end

  // Parabolic refinement terms and frequency bounds
  always_comb begin
    num_s    = $signed({1'b0, y2}) - $signed({1'b0, y0});
    num_abs  = num_s[ND_W] ? -num_s : num_s;
    den_s    = $signed({3'b0, y1, 2'b0}) - $signed({4'b0, y2, 1'b0})
             - $signed({4'b0, y0, 1'b0});
    den_abs  = den_s[24] ? -den_s : den_s;
    q_signed = $signed({{(LGW-36){1'b0}}, div_q[35:0]});
    lag_next = $signed({{(LGW-TW-16){1'b0}}, tau, 16'b0}) + (neg ? -q_signed : q_signed);
    lag_pos  = !lag[LGW-1] && (lag != '0);
    in_range = (div_q >= NW'(FREQ_LO)) && (div_q <= NW'(FREQ_HI))
             && !((div_q == NW'(FREQ_HI)) && (div_r != '0));
  end

  // Divider requests
  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    case (state)
      S_DIVS: begin
        div_start = 1'b1;
        div_num   = {prod, 16'b0};
        div_den   = rs;
      end
      S_REF: begin
        if (found && have_y2 && den_s != '0) begin
          div_start = 1'b1;
          div_num   = NW'({num_abs[ND_W-1:0], 16'b0});
          div_den   = SUM_W'(den_abs[23:0]);
        end
      end
      S_LAG: begin
        if (lag_pos) begin
          div_start = 1'b1;
          div_num   = NW'({cfg.rate, 24'b0});
          div_den   = SUM_W'(lag[LGW-2:0]);
        end
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  assign q_pop = (state == S_IDLE) && q_valid;

  // Ring memory: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (q_pop) ring[wp] <= q_data.sample;
    if (state == S_ACC && iss) begin
      rd_a <= ring[a_idx];
      rd_b <= ring[b_idx];
    end
  end

  // Main sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      wp        <= '0;
      fill      <= '0;
      iss       <= 1'b0;
      rd_v      <= 1'b0;
      sq_v      <= 1'b0;
      walk      <= 1'b0;
      found     <= 1'b0;
      have_y2   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      rd_v      <= (state == S_ACC) && iss;
      sq_v      <= rd_v;
      out_valid <= (state == S_FINISH) || (out_valid && !out_ready);

      case (state)
        S_IDLE: begin
          if (win_clear) begin
            wp   <= '0;
            fill <= '0;
          end else if (q_pop) begin
            wp   <= (wp_inc >= win) ? '0 : wp_inc[AW-1:0];
            fill <= fill_next;
          end
          if (q_pop && q_data.block_end) begin
            pend <= '0;
            if (fill_next >= win) begin
              t       <= TW'(1);
              i       <= '0;
              acc     <= '0;
              iss     <= 1'b1;
              rs      <= '0;
              walk    <= 1'b0;
              found   <= 1'b0;
              have_y2 <= 1'b0;
              prev_nd <= '0;
              state   <= S_ACC;
            end else begin
              state <= S_FINISH;
            end
          end
        end

        S_ACC: begin
          if (iss) begin
            if (i == hm1) iss <= 1'b0;
            else i <= i + 1'b1;
          end
          if (rd_v) sq <= sq_full[31:0];
          if (sq_v) acc <= acc + DW'(sq);
          if (!iss && !rd_v && !sq_v) state <= S_MUL;
        end

        S_MUL: begin
          rs    <= rs_sum[SUM_W] ? SUM_MAX : rs_sum[SUM_W-1:0];
          prod  <= PW'(acc) * PW'(t);
          state <= S_DIVS;
        end

        S_DIVS: begin
          state <= S_DIVW;
        end

        S_DIVW: begin
          if (div_done) begin
            prev_nd <= nd;
            if (hit_first) begin
              found <= 1'b1;
              walk  <= 1'b1;
              tau   <= t;
              y0    <= prev_nd;
              y1    <= nd;
            end
            if (go_down) begin
              tau <= t;
              y0  <= y1;
              y1  <= nd;
            end
            if (walk && !go_down) begin
              y2      <= nd;
              have_y2 <= 1'b1;
            end
            if (s_end) begin
              state <= S_REF;
            end else begin
              t     <= t + 1'b1;
              i     <= '0;
              acc   <= '0;
              iss   <= 1'b1;
              state <= S_ACC;
            end
          end
        end

        S_REF: begin
          neg <= num_s[ND_W] ^ den_s[24];
          if (!found) begin
            state <= S_FINISH;
          end else if (have_y2 && den_s != '0) begin
            state <= S_REFW;
          end else begin
            lag   <= $signed({{(LGW-TW-16){1'b0}}, tau, 16'b0});
            state <= S_LAG;
          end
        end

        S_REFW: begin
          if (div_done) begin
            lag   <= lag_next;
            state <= S_LAG;
          end
        end

        S_LAG: begin
          if (lag_pos) state <= S_FRQW;
          else state <= S_FINISH;
        end

        S_FRQW: begin
          if (div_done) begin
            if (in_range) begin
              pend.pitch_found    <= 1'b1;
              pend.frequency_q8   <= div_q[FREQ_W-1:0];
              pend.confidence_q16 <= (y1[ND_W-1:16] != '0) ? '0
                                   : CONF_W'(17'h10000 - {1'b0, y1[15:0]});
              pend.voiced         <= (y1 < cfg.threshold);
            end
            state <= S_FINISH;
          end
        end

        S_FINISH: begin
          if (!out_valid || out_ready) begin
            out_data <= pend;
            state    <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* rtl/core/yin_pitch_detector.sv */
// Top level of the YIN pitch detector: configuration registers, input front and engine.
// Every input beat is one audio sample; a sample beat is taken into a four-entry queue and
// then written to the sample ring by the engine while it is idle, so a stream of plain samples
// runs at one beat per clock while the engine is idle. A beat with block_end gives exactly one
// result beat. With the ring full the engine examines lags t = 1 upward and stops one lag after
// the dip is found (or at the last lag H-1, H = window/2); each lag reads H sample pairs from
// the two-port ring into one squarer and then normalises through the shared bit-serial divider,
// whose dividend width is NW = 2*clog2(MAX_WINDOW) + 46 (70 at the default depth). Refinement
// and the frequency division use the same divider after the search. While the engine runs,
// new samples wait in the queue.
module yin_pitch_detector
  import ypd_pkg::*;
#(
  parameter int MAX_WINDOW = 4096
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_beat_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_beat_t             out_data
);

  localparam int WW = $clog2(MAX_WINDOW + 1);

  logic [THRESH_W-1:0] threshold;
  logic [RATE_W-1:0]   rate;
  logic [WINREG_W-1:0] win_raw;
  logic [WW-1:0]       win_eff;
  logic                win_clear;
  cfg_t                cfg;
  logic                q_full;
  logic                q_pop;
  logic                q_valid;
  in_beat_t            q_data;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THRESHOLD_RST;
      rate      <= RATE_RST;
      win_raw   <= WINDOW_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_THRESHOLD: threshold <= cfg_data[THRESH_W-1:0];
        CFG_RATE:      rate      <= cfg_data;
        CFG_WINDOW:    win_raw   <= cfg_data[WINREG_W-1:0];
        default:       threshold <= threshold;
      endcase
    end
  end

  // Window clamped to MIN_WINDOW from below and to the ring depth from above
  always_comb begin
    if (win_raw < MIN_WINDOW) win_eff = WW'(MIN_WINDOW);
    else if (win_raw > MAX_WINDOW) win_eff = WW'(MAX_WINDOW);
    else win_eff = WW'(win_raw);
  end

  assign win_clear     = cfg_we && (cfg_index == CFG_WINDOW);
  assign cfg.threshold = threshold;
  assign cfg.rate      = rate;

  // Front: accept beats while the queue has room
  assign in_ready = !q_full;

  ypd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (in_valid && in_ready),
    .push_data (in_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_data),
    .not_empty (q_valid)
  );

  ypd_engine #(.MAX_WINDOW(MAX_WINDOW)) u_engine (
    .clk       (clk),
    .rst       (rst),
    .win       (win_eff),
    .win_clear (win_clear),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

`ifndef ASSERT_OFF
  // A result without a pitch carries all-zero fields.
  a_zero_when_none : assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.pitch_found |->
      out_data.frequency_q8 == '0 && out_data.confidence_q16 == '0 && !out_data.voiced)
    else $error("result without pitch has non-zero fields");

  // A reported pitch lies within the detection band.
  a_freq_band : assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.pitch_found |->
      out_data.frequency_q8 >= FREQ_LO && out_data.frequency_q8 <= FREQ_HI)
    else $error("reported frequency outside band");

  // The dip that gives a pitch is always below threshold.
  a_found_voiced : assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.pitch_found |-> out_data.voiced)
    else $error("pitch reported without voicing");
`endif

endmodule
